### hdl/binary_edge_detector_assert.svh
// Assertion macros used by the checker module of the edge detector.
`ifndef BINARY_EDGE_DETECTOR_ASSERT_SVH
`define BINARY_EDGE_DETECTOR_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define BED_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define BED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bed_pkg.sv
`default_nettype none

package bed_pkg;

   // Geometry and field widths
   localparam int BED_MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT      = 4096;
   localparam int MIN_WIDTH       = 2;
   localparam int MIN_HEIGHT      = 1;
   localparam int WIDTH_REG_W     = 9;
   localparam int HEIGHT_REG_W    = 13;
   localparam int THRESHOLD_W     = 8;
   localparam int COLOR_W         = 8;
   localparam int SUM_W           = 10;
   localparam int OUT_COLUMN_W    = 8;
   localparam int OUT_ROW_W       = 12;
   localparam int SLOT_ROW_W      = 13;
   localparam int EDGE_W          = 8;

   // Configuration port
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAY_THRESHOLD = 2'd2;

   // Reset values of the registers
   localparam int RESET_WIDTH     = 256;
   localparam int RESET_HEIGHT    = 256;
   localparam int RESET_THRESHOLD = 127;

   // Gray level is the mean of three channels
   localparam int GRAY_DIVISOR    = 3;

   // Line memories: the current row and the two above it
   localparam int LINE_COUNT      = 3;
   localparam int LINE_SEL_W      = 2;

   // Result codes
   localparam logic [EDGE_W-1:0] EDGE_MARK = 8'd0;
   localparam logic [EDGE_W-1:0] NOT_EDGE  = 8'd255;

   // Border flags of the pixel under test
   typedef struct packed {
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } pos_flags_type;

   // Binary neighborhood held between words
   typedef struct packed {
      logic prev_bit;   // one slot back, row below the center
      logic mid_near;   // center
      logic mid_far;    // left of center
      logic top_near;   // above center
      logic top_far;    // above left of center
   } window_type;

endpackage

`default_nettype wire

### hdl/binary_edge_detector.sv
// Channel  Direction  Handshake         Word
// req      in         req_valid/stall   is_pixel, red, green, blue
// rsp      out        rsp_valid/stall   edge_value, out_column, out_row, frame_last
// csr      in         csr_valid/ready   csr_index, csr_data (register write)
//
// One word is accepted per cycle while req_stall is low; a result passes stage one,
// then its register, after the word that completes its neighborhood (one line plus
// one pixel later) is accepted. The three line memories are each read once per word;
// only the one for the current row is written. Reset is synchronous; it restores the
// register defaults and an empty pipeline, and no clearing pass is needed.
// A stalled result register stops stage one when it holds a result, raising req_stall.

`default_nettype none

module binary_edge_detector
   import bed_pkg::*;
#(
   parameter int MAX_WIDTH = BED_MAX_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_is_pixel,
   input  wire logic [COLOR_W-1:0]      req_red,
   input  wire logic [COLOR_W-1:0]      req_green,
   input  wire logic [COLOR_W-1:0]      req_blue,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [EDGE_W-1:0]            rsp_edge_value,
   output logic [OUT_COLUMN_W-1:0]      rsp_out_column,
   output logic [OUT_ROW_W-1:0]         rsp_out_row,
   output logic                         rsp_frame_last,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int RESET_WIDTH_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int LIMIT_RESET = GRAY_DIVISOR * RESET_THRESHOLD + GRAY_DIVISOR - 1;

   // Configuration, held as last column, last row and sum limit
   logic [COL_W-1:0]         width_last_ff, width_last_in;
   logic [OUT_ROW_W-1:0]     height_last_ff, height_last_in;
   logic [SUM_W-1:0]         limit_ff, limit_in;
   logic                     csr_write;
   logic                     geometry_write;

   // Slot position
   logic [COL_W-1:0]         slot_column_ff, slot_column_in;
   logic [SLOT_ROW_W-1:0]    slot_row_ff, slot_row_in;
   logic [LINE_SEL_W-1:0]    line_sel_ff, line_sel_in;

   // Accept-side decode
   logic                     req_accept;
   logic                     in_frame;
   logic                     bubble;
   logic                     push;
   logic [SUM_W-1:0]         color_sum;
   logic                     pixel_bit;
   logic                     col_nonzero;
   logic [COL_W-1:0]         center_col;
   logic [SLOT_ROW_W-1:0]    row_back;
   logic [SLOT_ROW_W-1:0]    center_row;
   logic                     emit;
   pos_flags_type            flags;
   logic                     frame_end;

   // Stage one
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_emit_ff;
   logic                     s1_bit_ff;
   logic [LINE_SEL_W-1:0]    s1_sel_ff;
   logic [COL_W-1:0]         s1_col_ff;
   logic [OUT_ROW_W-1:0]     s1_row_ff;
   pos_flags_type            s1_flags_ff;
   logic                     s1_go;
   logic                     line_rd_ff [LINE_COUNT];
   logic [LINE_SEL_W-1:0]    up_idx;
   logic [LINE_SEL_W-1:0]    up2_idx;
   logic                     up_bit;
   logic                     up2_bit;
   window_type               win_ff, win_in;
   logic                     any_white;
   logic                     is_edge;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [EDGE_W-1:0]        rsp_edge_value_ff;
   logic [OUT_COLUMN_W-1:0]  rsp_out_column_ff;
   logic [OUT_ROW_W-1:0]     rsp_out_row_ff;
   logic                     rsp_frame_last_ff;

   // ---------------------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------------------

   assign csr_ready      = 1'b1;
   assign csr_write      = csr_valid & csr_ready;
   assign geometry_write = csr_write &
                           ((csr_index == CSR_IMAGE_WIDTH) || (csr_index == CSR_IMAGE_HEIGHT));

   // Clamp geometry at write time
   always_comb begin
      int unsigned width_req;
      int unsigned height_req;
      int unsigned width_eff;
      int unsigned height_eff;
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      limit_in       = limit_ff;
      width_req      = 32'(csr_data[WIDTH_REG_W-1:0]);
      height_req     = 32'(csr_data[HEIGHT_REG_W-1:0]);
      width_eff      = width_req;
      height_eff     = height_req;
      if (width_req < MIN_WIDTH) begin
         width_eff = MIN_WIDTH;
      end else if (width_req > MAX_WIDTH) begin
         width_eff = MAX_WIDTH;
      end
      if (height_req < MIN_HEIGHT) begin
         height_eff = MIN_HEIGHT;
      end else if (height_req > MAX_HEIGHT) begin
         height_eff = MAX_HEIGHT;
      end
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_last_in = COL_W'(width_eff - 1);
            end
            CSR_IMAGE_HEIGHT: begin
               height_last_in = OUT_ROW_W'(height_eff - 1);
            end
            CSR_GRAY_THRESHOLD: begin
               // mean > t  <=>  sum > 3t + 2
               limit_in = SUM_W'(GRAY_DIVISOR * 32'(csr_data[THRESHOLD_W-1:0]) +
                                 GRAY_DIVISOR - 1);
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Accept side: binarize, locate the pixel under test, advance the slot
   // ---------------------------------------------------------------------------------

   assign req_accept  = req_valid & ~req_stall;
   assign in_frame    = slot_row_ff <= {1'b0, height_last_ff};
   assign bubble      = ~req_is_pixel & in_frame;
   assign push        = req_accept & ~bubble;
   assign color_sum   = {2'b00, req_red} + {2'b00, req_green} + {2'b00, req_blue};
   assign pixel_bit   = in_frame & (color_sum > limit_ff);

   // The center trails by one line plus one pixel
   assign col_nonzero = slot_column_ff != '0;
   assign center_col  = col_nonzero ? (slot_column_ff - 1'b1) : width_last_ff;
   assign row_back    = col_nonzero ? SLOT_ROW_W'(1) : SLOT_ROW_W'(2);
   assign center_row  = slot_row_ff - row_back;
   assign emit        = (slot_row_ff >= row_back) &&
                        (center_row <= {1'b0, height_last_ff});

   assign flags.first_row = center_row == '0;
   assign flags.last_row  = center_row[OUT_ROW_W-1:0] == height_last_ff;
   assign flags.first_col = center_col == '0;
   assign flags.last_col  = center_col == width_last_ff;
   assign frame_end       = emit & flags.last_row & flags.last_col;

   // Advance the slot; restart on frame end or geometry change
   always_comb begin
      slot_column_in = slot_column_ff;
      slot_row_in    = slot_row_ff;
      line_sel_in    = line_sel_ff;
      if (geometry_write) begin
         slot_column_in = '0;
         slot_row_in    = '0;
         line_sel_in    = '0;
      end else if (push) begin
         if (frame_end) begin
            slot_column_in = '0;
            slot_row_in    = '0;
            line_sel_in    = '0;
         end else if (slot_column_ff == width_last_ff) begin
            slot_column_in = '0;
            slot_row_in    = slot_row_ff + 1'b1;
            line_sel_in    = (line_sel_ff == LINE_SEL_W'(LINE_COUNT - 1)) ?
                             '0 : (line_sel_ff + 1'b1);
         end else begin
            slot_column_in = slot_column_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Line memories: write the current row, read the two rows above at the same column
   // ---------------------------------------------------------------------------------

   for (genvar i = 0; i < LINE_COUNT; i++) begin : g_line
      logic line_mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (push) begin
            if (line_sel_ff == LINE_SEL_W'(i)) begin
               line_mem[slot_column_ff] <= pixel_bit;
            end
            line_rd_ff[i] <= line_mem[slot_column_ff];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage one: shift the window and judge the center
   // ---------------------------------------------------------------------------------

   assign s1_go       = s1_valid_ff & (~s1_emit_ff | ~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = s1_valid_ff & ~s1_go;
   assign s1_valid_in = push | (s1_valid_ff & ~s1_go);

   assign up_idx  = (s1_sel_ff == '0) ? LINE_SEL_W'(LINE_COUNT - 1) : (s1_sel_ff - 1'b1);
   assign up2_idx = (s1_sel_ff == LINE_SEL_W'(LINE_COUNT - 1)) ? '0 : (s1_sel_ff + 1'b1);
   assign up_bit  = line_rd_ff[up_idx];
   assign up2_bit = line_rd_ff[up2_idx];

   // Neighbors outside the image count as black
   assign any_white =
      (win_ff.top_far  & ~s1_flags_ff.first_row & ~s1_flags_ff.first_col) |
      (s1_bit_ff       & ~s1_flags_ff.last_row  & ~s1_flags_ff.last_col)  |
      (up_bit          & ~s1_flags_ff.last_col)                           |
      (win_ff.prev_bit & ~s1_flags_ff.last_row)                           |
      (win_ff.top_near & ~s1_flags_ff.first_row)                          |
      (win_ff.mid_far  & ~s1_flags_ff.first_col);
   assign is_edge = ~win_ff.mid_near & any_white;

   always_comb begin
      win_in = win_ff;
      if (s1_go) begin
         win_in.prev_bit = s1_bit_ff;
         win_in.mid_near = up_bit;
         win_in.mid_far  = win_ff.mid_near;
         win_in.top_near = up2_bit;
         win_in.top_far  = win_ff.top_near;
      end
   end

   // Hold stage payload until the next word enters
   always_ff @(posedge clock) begin
      if (push) begin
         s1_emit_ff  <= emit;
         s1_bit_ff   <= pixel_bit;
         s1_sel_ff   <= line_sel_ff;
         s1_col_ff   <= center_col;
         s1_row_ff   <= center_row[OUT_ROW_W-1:0];
         s1_flags_ff <= flags;
      end
   end

   // ---------------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------------

   assign rsp_valid_in = (s1_go & s1_emit_ff) | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_edge_value_ff <= is_edge ? EDGE_MARK : NOT_EDGE;
         rsp_out_column_ff <= OUT_COLUMN_W'(s1_col_ff);
         rsp_out_row_ff    <= s1_row_ff;
         rsp_frame_last_ff <= s1_flags_ff.last_row & s1_flags_ff.last_col;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = rsp_edge_value_ff;
   assign rsp_out_column = rsp_out_column_ff;
   assign rsp_out_row    = rsp_out_row_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   // ---------------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------------

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(RESET_WIDTH_EFF - 1);
         height_last_ff <= OUT_ROW_W'(RESET_HEIGHT - 1);
         limit_ff       <= SUM_W'(LIMIT_RESET);
         slot_column_ff <= '0;
         slot_row_ff    <= '0;
         line_sel_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         win_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         limit_ff       <= limit_in;
         slot_column_ff <= slot_column_in;
         slot_row_ff    <= slot_row_in;
         line_sel_ff    <= line_sel_in;
         s1_valid_ff    <= s1_valid_in;
         win_ff         <= win_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hdl/bed_checker.sv
`default_nettype none

`include "binary_edge_detector_assert.svh"

module bed_checker
   import bed_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic [EDGE_W-1:0]       rsp_edge_value,
   input  wire logic [OUT_COLUMN_W-1:0] rsp_out_column,
   input  wire logic [OUT_ROW_W-1:0]    rsp_out_row,
   input  wire logic                    rsp_frame_last
);

   // A result carries only the two legal codes
   `BED_ASSERT_SAME(a_edge_code, clock, reset, rsp_valid, (rsp_edge_value == EDGE_MARK || rsp_edge_value == NOT_EDGE), "edge value is neither mark nor blank")

   // The input side stalls only behind a blocked result
   `BED_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, (rsp_valid && rsp_stall), "input stalled without a blocked result")

   // A fresh result comes from an accepted word that has passed through stage one
   `BED_ASSERT_SAME(a_result_source, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result appeared without an accepted word")

   // Hold a stalled result word
   `BED_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall), (rsp_valid && $stable(rsp_edge_value) && $stable(rsp_out_column) && $stable(rsp_out_row) && $stable(rsp_frame_last)), "stalled result changed")

endmodule

bind binary_edge_detector bed_checker u_bed_checker (.*);

`default_nettype wire
